/* sv/obb_corner_rotation_top_defines.svh */
// assertion macros for the oriented box corner block
// used by obb_corner_rotation_top; expects aclk and aresetn in scope
`ifndef OBB_CORNER_ROTATION_TOP_DEFINES_SVH
`define OBB_CORNER_ROTATION_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define OBB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define OBB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/obb_pkg.sv */
// types and constants for the oriented box corner block
// no dependencies; imported by obb_corner_rotation_top
package obb_pkg;

    localparam int NUM_CORNERS = 8;
    localparam int CNT_W       = $clog2(NUM_CORNERS);
    localparam logic [CNT_W-1:0] LAST_CORNER = CNT_W'(NUM_CORNERS - 1);

    // fixed-point widths
    localparam int COORD_W  = 32;              // Q16.16
    localparam int QUAT_W   = 16;              // Q2.14
    localparam int QPROD_W  = 2 * QUAT_W;      // Q.28 products
    localparam int MPRE_W   = QPROD_W + 3;     // matrix entry before rounding
    localparam int MRND_SH  = 4;               // Q.28 -> Q.24
    localparam int MAT_W    = MPRE_W - MRND_SH;
    localparam int MH_W     = MAT_W + COORD_W; // entry times half extent
    localparam int ACC_W    = MH_W + 3;        // three-term signed sum
    localparam int ORND_SH  = 24;              // Q.40 -> Q16.16
    localparam int SUM_W    = ACC_W - ORND_SH + 2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [QUAT_W-1:0]  quat_t;
    typedef logic signed [QPROD_W-1:0] qprod_t;
    typedef logic signed [MPRE_W-1:0]  mpre_t;
    typedef logic signed [MAT_W-1:0]   mat_t;
    typedef logic signed [MH_W-1:0]    mh_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic signed [SUM_W-1:0]   sum_t;

    // identity in Q.28
    localparam mpre_t ONE_Q28 = mpre_t'(64'sd1 <<< 28);

    // per-corner negate mask, bit 0 = x, bit 1 = y, bit 2 = z
    localparam logic [2:0] CORNER_NEG [NUM_CORNERS] = '{
        3'b000, 3'b001, 3'b011, 3'b010, 3'b110, 3'b111, 3'b101, 3'b100
    };

    typedef struct packed {
        coord_t center_x;
        coord_t center_y;
        coord_t center_z;
        coord_t half_x;
        coord_t half_y;
        coord_t half_z;
        quat_t  quat_w;
        quat_t  quat_x;
        quat_t  quat_y;
        quat_t  quat_z;
    } obb_in_t;

    typedef struct packed {
        logic [CNT_W-1:0] corner_index;
        coord_t           corner_x;
        coord_t           corner_y;
        coord_t           corner_z;
        logic             clipped;
        logic             last_corner;
    } obb_out_t;

endpackage

/* sv/obb_corner_rotation_top.sv */
// oriented box corners from center, half extents and quaternion
// depends on obb_pkg and obb_corner_rotation_top_defines.svh
//
//  channel | ports                     | transaction
//  --------+---------------------------+-------------------------------------
//  input   | s_valid, s_ready, s_data  | one box: center, half extents, quat
//  output  | m_valid, m_ready, m_data  | one corner, eight per box, in order
//
// five register stages: quaternion products, rounded matrix, matrix times
// half extents, signed row sums, rounding/center add/saturation
// first corner reaches m_valid through stages 1, 2, 3, d and e; one corner per cycle unless m_ready stalls
// at full rate boxes are taken at the pace set by the corner sequencer
// in stage 3 which holds a box for its eight corners; stages 1-2 buffer two
// more boxes. reset (aresetn low, synchronous) clears all valid bits
// a stall on m_ready backs up stage by stage; nothing is dropped or repeated
`include "obb_corner_rotation_top_defines.svh"

module obb_corner_rotation_top (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  obb_pkg::obb_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output obb_pkg::obb_out_t m_data
);
    import obb_pkg::*;

    // ---------------- handshake chain ----------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, d_valid_reg, e_valid_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic e_ready, d_ready, s3_ready, s2_ready, s1_ready;
    logic s3_load, s3_done;

    assign e_ready  = !e_valid_reg || m_ready;
    assign d_ready  = !d_valid_reg || e_ready;
    assign s3_done  = s3_valid_reg && d_ready && (cnt_reg == LAST_CORNER);
    assign s3_ready = !s3_valid_reg || s3_done;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s_ready  = s1_ready;
    assign s3_load  = s2_valid_reg && s3_ready;

    // ---------------- stage 1: quaternion products ----------------
    qprod_t s1_xx_reg, s1_yy_reg, s1_zz_reg, s1_xy_reg, s1_xz_reg, s1_yz_reg;
    qprod_t s1_wx_reg, s1_wy_reg, s1_wz_reg;
    coord_t s1_c_reg [3];
    coord_t s1_h_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_ready) begin
            s1_valid_reg <= s_valid;
        end
        if (s1_ready && s_valid) begin
            s1_xx_reg <= qprod_t'(s_data.quat_x) * qprod_t'(s_data.quat_x);
            s1_yy_reg <= qprod_t'(s_data.quat_y) * qprod_t'(s_data.quat_y);
            s1_zz_reg <= qprod_t'(s_data.quat_z) * qprod_t'(s_data.quat_z);
            s1_xy_reg <= qprod_t'(s_data.quat_x) * qprod_t'(s_data.quat_y);
            s1_xz_reg <= qprod_t'(s_data.quat_x) * qprod_t'(s_data.quat_z);
            s1_yz_reg <= qprod_t'(s_data.quat_y) * qprod_t'(s_data.quat_z);
            s1_wx_reg <= qprod_t'(s_data.quat_w) * qprod_t'(s_data.quat_x);
            s1_wy_reg <= qprod_t'(s_data.quat_w) * qprod_t'(s_data.quat_y);
            s1_wz_reg <= qprod_t'(s_data.quat_w) * qprod_t'(s_data.quat_z);
            s1_c_reg  <= '{s_data.center_x, s_data.center_y, s_data.center_z};
            s1_h_reg  <= '{s_data.half_x, s_data.half_y, s_data.half_z};
        end
    end

    // ---------------- stage 2: rotation matrix, rounded to Q.24 ----------------
    mpre_t m_pre [9];
    mat_t  s2_m_next [9];
    mat_t  s2_m_reg [9];
    coord_t s2_c_reg [3];
    coord_t s2_h_reg [3];

    always_comb begin
        m_pre[0] = ONE_Q28 - ((mpre_t'(s1_yy_reg) + mpre_t'(s1_zz_reg)) <<< 1);
        m_pre[1] = (mpre_t'(s1_xy_reg) - mpre_t'(s1_wz_reg)) <<< 1;
        m_pre[2] = (mpre_t'(s1_xz_reg) + mpre_t'(s1_wy_reg)) <<< 1;
        m_pre[3] = (mpre_t'(s1_xy_reg) + mpre_t'(s1_wz_reg)) <<< 1;
        m_pre[4] = ONE_Q28 - ((mpre_t'(s1_xx_reg) + mpre_t'(s1_zz_reg)) <<< 1);
        m_pre[5] = (mpre_t'(s1_yz_reg) - mpre_t'(s1_wx_reg)) <<< 1;
        m_pre[6] = (mpre_t'(s1_xz_reg) - mpre_t'(s1_wy_reg)) <<< 1;
        m_pre[7] = (mpre_t'(s1_yz_reg) + mpre_t'(s1_wx_reg)) <<< 1;
        m_pre[8] = ONE_Q28 - ((mpre_t'(s1_xx_reg) + mpre_t'(s1_yy_reg)) <<< 1);
        // round half up: add 2^3, floor by 2^4
        for (int k = 0; k < 9; k++) begin
            s2_m_next[k] = mat_t'((m_pre[k] + mpre_t'(1 <<< (MRND_SH - 1))) >>> MRND_SH);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_valid_reg <= s1_valid_reg;
        end
        if (s2_ready && s1_valid_reg) begin
            s2_m_reg <= s2_m_next;
            s2_c_reg <= s1_c_reg;
            s2_h_reg <= s1_h_reg;
        end
    end

    // ---------------- stage 3: matrix times half extents, corner sequencer ----------------
    mh_t    s3_mh_next [9];
    mh_t    s3_mh_reg [9];
    coord_t s3_c_reg [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                s3_mh_next[i*3+j] = mh_t'(s2_m_reg[i*3+j]) * mh_t'(s2_h_reg[j]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
            cnt_reg      <= '0;
        end else if (s3_ready) begin
            s3_valid_reg <= s2_valid_reg;
            cnt_reg      <= '0;
        end else if (s3_valid_reg && d_ready) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        if (s3_load) begin
            s3_mh_reg <= s3_mh_next;
            s3_c_reg  <= s2_c_reg;
        end
    end

    // ---------------- stage d: signed row sums for one corner ----------------
    logic [2:0] neg;
    acc_t       term [9];
    acc_t       d_acc_next [3];
    acc_t       d_acc_reg [3];
    coord_t     d_c_reg [3];
    logic [CNT_W-1:0] d_idx_reg;

    always_comb begin
        neg = CORNER_NEG[cnt_reg];
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                term[i*3+j] = neg[j] ? -acc_t'(s3_mh_reg[i*3+j]) : acc_t'(s3_mh_reg[i*3+j]);
            end
            d_acc_next[i] = term[i*3] + term[i*3+1] + term[i*3+2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (d_ready) begin
            d_valid_reg <= s3_valid_reg;
        end
        if (d_ready && s3_valid_reg) begin
            d_acc_reg <= d_acc_next;
            d_c_reg   <= s3_c_reg;
            d_idx_reg <= cnt_reg;
        end
    end

    // ---------------- stage e: round, add center, saturate ----------------
    sum_t     e_sum [3];
    coord_t   e_coord [3];
    logic [2:0] e_clip;
    obb_out_t m_data_next;
    obb_out_t m_data_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            e_sum[i] = sum_t'((d_acc_reg[i] + acc_t'(1 <<< (ORND_SH - 1))) >>> ORND_SH)
                     + sum_t'(d_c_reg[i]);
            if (e_sum[i] > sum_t'(32'sh7fff_ffff)) begin
                e_coord[i] = 32'sh7fff_ffff;
                e_clip[i]  = 1'b1;
            end else if (e_sum[i] < sum_t'(32'sh8000_0000)) begin
                e_coord[i] = 32'sh8000_0000;
                e_clip[i]  = 1'b1;
            end else begin
                e_coord[i] = coord_t'(e_sum[i]);
                e_clip[i]  = 1'b0;
            end
        end
        m_data_next.corner_index = d_idx_reg;
        m_data_next.corner_x     = e_coord[0];
        m_data_next.corner_y     = e_coord[1];
        m_data_next.corner_z     = e_coord[2];
        m_data_next.clipped      = |e_clip;
        m_data_next.last_corner  = (d_idx_reg == LAST_CORNER);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (e_ready) begin
            e_valid_reg <= d_valid_reg;
        end
        if (e_ready && d_valid_reg) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = e_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------- assertions ----------------
    `OBB_ASSERT_NOW(a_no_load_mid_box, s3_valid_reg && !s3_done, !s3_load, "box replaced before its eighth corner")
    `OBB_ASSERT_NOW(a_clip_at_rail, m_valid && m_data.clipped, (m_data.corner_x == 32'sh7fff_ffff) || (m_data.corner_x == 32'sh8000_0000) || (m_data.corner_y == 32'sh7fff_ffff) || (m_data.corner_y == 32'sh8000_0000) || (m_data.corner_z == 32'sh7fff_ffff) || (m_data.corner_z == 32'sh8000_0000), "clipped corner not at a rail")
    `OBB_ASSERT_NEXT(a_cnt_advance, s3_valid_reg && d_ready && !s3_done, s3_valid_reg && (cnt_reg == $past(cnt_reg) + CNT_W'(1)), "corner counter skipped")

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// self-checking bench for obb_corner_rotation_top: boxes in, eight rotated corners out
// depends on obb_pkg and the rtl only; corner values come from a local fixed-point model

module tb;
    import obb_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_BOXES  = 212;
    localparam int GAP_MAX       = 13;
    localparam int HOLD_AFTER    = 600;   // corners taken before the long hold-off
    localparam int HOLD_CYCLES   = 300;
    localparam int STUCK_LIMIT   = 2000;  // cycles with no transaction on either side
    localparam int DRAIN_CYCLES  = 16;

    // fixed-point anchors
    localparam longint ONE_Q28   = 64'sd268435456;
    localparam longint MAT_RND   = 64'sd8;        // half lsb of q.24
    localparam longint OUT_RND   = 64'sd8388608;  // half lsb of q16.16 from q.40
    localparam longint COORD_TOP = 64'sd2147483647;
    localparam longint COORD_BOT = -64'sd2147483648;

    localparam coord_t C_MAX = 32'sh7fff_ffff;
    localparam coord_t C_MIN = 32'sh8000_0000;
    localparam coord_t F_ONE = 32'sh0001_0000;
    localparam quat_t  Q_ONE = 16'sh4000;
    localparam quat_t  Q_MAX = 16'sh7fff;
    localparam quat_t  Q_MIN = 16'sh8000;
    localparam quat_t  Q_45  = 16'sh2d41;     // cos/sin of 45 degrees in q2.14

    // negate mask per corner, bit 0 = x; order +++ -++ --+ +-+ +-- --- -+- ++-
    localparam bit [2:0] FLIP_MASK [NUM_CORNERS] = '{
        3'b000, 3'b001, 3'b011, 3'b010, 3'b110, 3'b111, 3'b101, 3'b100
    };

    typedef obb_out_t box_corners_t [NUM_CORNERS];

    // one row of the directed table; corner 0 may be given by hand
    typedef struct {
        obb_in_t box;
        bit      typed;
        coord_t  c0_x;
        coord_t  c0_y;
        coord_t  c0_z;
        bit      c0_clip;
    } probe_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    obb_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    obb_out_t m_data;

    obb_out_t pending_corners [$];
    probe_t   probes [$];
    int       mismatches  = 0;
    int       src_gap_max = 0;
    int       stuck       = 0;

    obb_corner_rotation_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    function automatic obb_in_t make_box(input coord_t cx, cy, cz, hx, hy, hz,
                                         input quat_t qw, qx, qy, qz);
        obb_in_t b;
        b.center_x = cx;
        b.center_y = cy;
        b.center_z = cz;
        b.half_x   = hx;
        b.half_y   = hy;
        b.half_z   = hz;
        b.quat_w   = qw;
        b.quat_x   = qx;
        b.quat_y   = qy;
        b.quat_z   = qz;
        return b;
    endfunction

    // rotation matrix from the raw quaternion, then center + matrix * signed extents
    function automatic box_corners_t rotate_box(input obb_in_t b);
        box_corners_t res;
        longint w, x, y, z, acc, r;
        longint rot [3][3];
        longint ctr [3];
        longint half [3];
        longint arm [3];
        bit     clip;
        w = b.quat_w;
        x = b.quat_x;
        y = b.quat_y;
        z = b.quat_z;
        ctr[0]  = b.center_x;
        ctr[1]  = b.center_y;
        ctr[2]  = b.center_z;
        half[0] = b.half_x;
        half[1] = b.half_y;
        half[2] = b.half_z;

        // q.28 entries, rounded half up to q.24
        rot[0][0] = ONE_Q28 - 2 * (y * y + z * z);
        rot[0][1] = 2 * (x * y - w * z);
        rot[0][2] = 2 * (x * z + w * y);
        rot[1][0] = 2 * (x * y + w * z);
        rot[1][1] = ONE_Q28 - 2 * (x * x + z * z);
        rot[1][2] = 2 * (y * z - w * x);
        rot[2][0] = 2 * (x * z - w * y);
        rot[2][1] = 2 * (y * z + w * x);
        rot[2][2] = ONE_Q28 - 2 * (x * x + y * y);
        foreach (rot[i, j]) rot[i][j] = (rot[i][j] + MAT_RND) >>> 4;

        for (int k = 0; k < NUM_CORNERS; k++) begin
            // negation is done at 64 bits, so the most negative extent does not wrap
            for (int j = 0; j < 3; j++) arm[j] = FLIP_MASK[k][j] ? -half[j] : half[j];
            clip = 1'b0;
            res[k].corner_index = CNT_W'(k);
            for (int i = 0; i < 3; i++) begin
                acc = rot[i][0] * arm[0] + rot[i][1] * arm[1] + rot[i][2] * arm[2];
                r = ((acc + OUT_RND) >>> 24) + ctr[i];
                if (r > COORD_TOP) begin
                    r = COORD_TOP;
                    clip = 1'b1;
                end else if (r < COORD_BOT) begin
                    r = COORD_BOT;
                    clip = 1'b1;
                end
                case (i)
                    0: res[k].corner_x = r[31:0];
                    1: res[k].corner_y = r[31:0];
                    default: res[k].corner_z = r[31:0];
                endcase
            end
            res[k].clipped     = clip;
            res[k].last_corner = (k == NUM_CORNERS - 1);
        end
        return res;
    endfunction

    function automatic coord_t extreme_coord();
        case ($urandom_range(0, 6))
            0: return C_MAX;
            1: return C_MIN;
            2: return '0;
            3: return -32'sd1;
            4: return 32'sd1;
            5: return F_ONE;
            default: return -F_ONE;
        endcase
    endfunction

    function automatic quat_t extreme_quat();
        case ($urandom_range(0, 5))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3: return Q_ONE;
            4: return -Q_ONE;
            default: return -16'sd1;
        endcase
    endfunction

    // values within +-256.0
    function automatic coord_t mid_coord();
        return coord_t'(int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
    endfunction

    // drive one box, wait for its transaction, then queue its corners
    task automatic offer_box(input probe_t pr);
        box_corners_t corners;
        int gap;
        gap = $urandom_range(src_gap_max, 0);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= pr.box;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        corners = rotate_box(pr.box);
        if (pr.typed) begin
            corners[0].corner_x = pr.c0_x;
            corners[0].corner_y = pr.c0_y;
            corners[0].corner_z = pr.c0_z;
            corners[0].clipped  = pr.c0_clip;
        end
        foreach (corners[k]) pending_corners.push_back(corners[k]);
    endtask

    // stop offering until every queued corner has come back
    task automatic drain_boxes();
        s_valid <= 1'b0;
        while (pending_corners.size() != 0) @(posedge aclk);
    endtask

    task automatic cmp_field(input string what, input int idx,
                             input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: corner %0d %s expected %h actual %h", $time, idx, what, want, got);
        end
    endtask

    // result side: compare each corner transaction with the oldest prediction
    always @(posedge aclk) begin
        obb_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_corners.size() == 0) begin
                mismatches++;
                $display("%0t: corner transaction expected none actual %h",
                         $time, m_data);
            end else begin
                want = pending_corners.pop_front();
                cmp_field("index", want.corner_index, want.corner_index, m_data.corner_index);
                cmp_field("x", want.corner_index, want.corner_x, m_data.corner_x);
                cmp_field("y", want.corner_index, want.corner_y, m_data.corner_y);
                cmp_field("z", want.corner_index, want.corner_z, m_data.corner_z);
                cmp_field("clipped", want.corner_index, want.clipped, m_data.clipped);
                cmp_field("last", want.corner_index, want.last_corner, m_data.last_corner);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck = 0;
        end else begin
            stuck++;
            if (stuck >= STUCK_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // receiver: random stalls per corner, one long hold-off to back up the pipe
    initial begin : corner_sink
        int stall;
        int taken;
        int snk_stall_max;
        bit held;
        taken = 0;
        snk_stall_max = 0;
        held = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (taken % 50 == 0)
                snk_stall_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
            if (!held && taken >= HOLD_AFTER) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                stall = $urandom_range(snk_stall_max, 0);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            taken++;
        end
    end

    // stimulus: directed table, then random boxes
    initial begin : box_source
        probe_t pr;
        real    qa [4];
        real    qn;
        int     kind;

        // directed rows with corner 0 typed in: zero and identity quaternions act as identity
        probes.push_back(probe_t'{make_box(0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                  1'b1, 0, 0, 0, 1'b0});
        probes.push_back(probe_t'{make_box(F_ONE, 2 * F_ONE, 3 * F_ONE, 0, 0, 0,
                                           Q_ONE, 0, 0, 0),
                                  1'b1, F_ONE, 2 * F_ONE, 3 * F_ONE, 1'b0});
        probes.push_back(probe_t'{make_box(0, 0, 0, C_MAX, C_MAX, C_MAX, 0, 0, 0, 0),
                                  1'b1, C_MAX, C_MAX, C_MAX, 1'b0});
        probes.push_back(probe_t'{make_box(C_MAX, C_MAX, C_MAX, F_ONE, F_ONE, F_ONE,
                                           Q_ONE, 0, 0, 0),
                                  1'b1, C_MAX, C_MAX, C_MAX, 1'b1});
        probes.push_back(probe_t'{make_box(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                                           0, 0, 0, 0),
                                  1'b1, C_MIN, C_MIN, C_MIN, 1'b1});
        // most negative extents: corner 0 stays exact, mirrored corners clamp high
        probes.push_back(probe_t'{make_box(0, 0, 0, C_MIN, C_MIN, C_MIN, Q_ONE, 0, 0, 0),
                                  1'b1, C_MIN, C_MIN, C_MIN, 1'b0});
        probes.push_back(probe_t'{make_box(0, 0, 0, F_ONE, 2 * F_ONE, 3 * F_ONE,
                                           Q_MIN, 0, 0, 0),
                                  1'b1, F_ONE, 2 * F_ONE, 3 * F_ONE, 1'b0});
        // predicted rows: quarter and half turns, non-unit and extreme quaternions
        probes.push_back(probe_t'{make_box(0, 0, 0, F_ONE, 2 * F_ONE, 3 * F_ONE,
                                           Q_45, 0, 0, Q_45), 1'b0, 0, 0, 0, 1'b0});
        probes.push_back(probe_t'{make_box(F_ONE, -F_ONE, 0, F_ONE, 2 * F_ONE, 3 * F_ONE,
                                           Q_45, Q_45, 0, 0), 1'b0, 0, 0, 0, 1'b0});
        probes.push_back(probe_t'{make_box(0, 5 * F_ONE, 0, 3 * F_ONE, F_ONE, 2 * F_ONE,
                                           Q_45, 0, Q_45, 0), 1'b0, 0, 0, 0, 1'b0});
        probes.push_back(probe_t'{make_box(0, 0, 0, F_ONE, F_ONE, F_ONE, 0, Q_ONE, 0, 0),
                                  1'b0, 0, 0, 0, 1'b0});
        probes.push_back(probe_t'{make_box(7 * F_ONE, 0, -F_ONE, -2 * F_ONE, -3 * F_ONE,
                                           -4 * F_ONE, Q_45, 0, 0, -Q_45),
                                  1'b0, 0, 0, 0, 1'b0});
        probes.push_back(probe_t'{make_box(0, 0, 0, 3 * F_ONE, 3 * F_ONE, 3 * F_ONE,
                                           Q_MAX, Q_MAX, Q_MAX, Q_MAX), 1'b0, 0, 0, 0, 1'b0});
        probes.push_back(probe_t'{make_box(F_ONE, F_ONE, F_ONE, F_ONE, F_ONE, F_ONE,
                                           Q_MIN, Q_MIN, Q_MIN, Q_MIN), 1'b0, 0, 0, 0, 1'b0});
        probes.push_back(probe_t'{make_box(0, 0, 0, C_MAX, C_MIN, C_MAX,
                                           Q_ONE, Q_ONE, Q_ONE, 0), 1'b0, 0, 0, 0, 1'b0});
        probes.push_back(probe_t'{make_box(C_MIN, C_MAX, 0, 4 * F_ONE, 4 * F_ONE, 4 * F_ONE,
                                           Q_45, Q_45, 0, 0), 1'b0, 0, 0, 0, 1'b0});
        probes.push_back(probe_t'{make_box(0, 0, 0, 32'sd1, 32'sd1, 32'sd1,
                                           -16'sd1, Q_MIN, Q_MAX, 16'sd1), 1'b0, 0, 0, 0, 1'b0});
        probes.push_back(probe_t'{make_box(-F_ONE, 0, F_ONE, 32'sd3, 0, 0,
                                           Q_45, 0, 0, Q_45), 1'b0, 0, 0, 0, 1'b0});

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (probes[i]) offer_box(probes[i]);
        drain_boxes();

        for (int n = 0; n < RANDOM_BOXES; n++) begin
            if (n % 30 == 0) begin
                case ($urandom_range(0, 3))
                    0: src_gap_max = 0;
                    1: src_gap_max = 4;
                    default: src_gap_max = GAP_MAX;
                endcase
            end
            if (n == RANDOM_BOXES / 2) drain_boxes();
            kind = $urandom_range(0, 7);
            pr.typed   = 1'b0;
            pr.c0_x    = '0;
            pr.c0_y    = '0;
            pr.c0_z    = '0;
            pr.c0_clip = 1'b0;
            case (kind)
                // raw bits everywhere
                0, 1: pr.box = make_box($urandom, $urandom, $urandom,
                                        $urandom, $urandom, $urandom,
                                        quat_t'($urandom), quat_t'($urandom),
                                        quat_t'($urandom), quat_t'($urandom));
                2: pr.box = make_box(extreme_coord(), extreme_coord(), extreme_coord(),
                                     extreme_coord(), extreme_coord(), extreme_coord(),
                                     extreme_quat(), extreme_quat(),
                                     extreme_quat(), extreme_quat());
                // realistic boxes with a unit quaternion
                default: begin
                    qn = 0.0;
                    for (int i = 0; i < 4; i++) begin
                        qa[i] = real'($urandom_range(0, 2000)) - 1000.0;
                        qn += qa[i] * qa[i];
                    end
                    if (qn < 1.0) begin
                        qa[0] = 1.0;
                        qn = 1.0;
                    end
                    qn = $sqrt(qn);
                    pr.box = make_box(mid_coord(), mid_coord(), mid_coord(),
                                      mid_coord(), mid_coord(), mid_coord(),
                                      quat_t'($rtoi(qa[0] / qn * 16384.0)),
                                      quat_t'($rtoi(qa[1] / qn * 16384.0)),
                                      quat_t'($rtoi(qa[2] / qn * 16384.0)),
                                      quat_t'($rtoi(qa[3] / qn * 16384.0)));
                end
            endcase
            offer_box(pr);
        end
        s_valid <= 1'b0;

        // wait out the pipeline, then report
        while (pending_corners.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
